// ===== src/fcbf_pkg.sv =====
// shared types, constants and codes of the flow controlled byte fifo
`default_nettype none
package fcbf_pkg;

	// default ring memory depth in bytes
	localparam int DEPTH_DEF = 4096;

	// field widths
	localparam int DATA_W = 8;
	localparam int OFF_W  = 12;
	localparam int CNT_W  = 13;
	localparam int CAP_W  = 13;
	localparam int TOT_W  = 32;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

	// register index codes, taken from the word address bit
	localparam logic REG_CAPACITY = 1'b0;

	// operation codes
	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_PEEK  = 3'd2,
		OP_DROP  = 3'd3,
		OP_END   = 3'd4
	} op_t;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_MEMRD
	} state_t;

	// one input transaction
	typedef struct packed {
		logic [2:0]        opcode;
		logic [DATA_W-1:0] data_in;
		logic [OFF_W-1:0]  offset;
		logic [CNT_W-1:0]  drop_count;
	} in_item_t;

	// one result transaction
	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic              ok;
		logic [CAP_W-1:0]  fill;
		logic [CAP_W-1:0]  space;
		logic [TOT_W-1:0]  total_written;
		logic [TOT_W-1:0]  total_read;
		logic              input_done;
		logic              at_eof;
	} res_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic fin_now;
		logic fin_mem;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic needs_mem;
	} sts_t;

endpackage
`default_nettype wire

// ===== src/fcbf_in_if.sv =====
// input channel interface of the byte fifo
`default_nettype none
interface fcbf_in_if;
	import fcbf_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic [DATA_W-1:0] data_in;
	logic [OFF_W-1:0]  offset;
	logic [CNT_W-1:0]  drop_count;

	modport source (output valid, output opcode, output data_in, output offset,
		output drop_count, input ready);
	modport sink (input valid, input opcode, input data_in, input offset,
		input drop_count, output ready);
endinterface
`default_nettype wire

// ===== src/fcbf_out_if.sv =====
// result channel interface of the byte fifo
`default_nettype none
interface fcbf_out_if;
	import fcbf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_out;
	logic              ok;
	logic [CAP_W-1:0]  fill;
	logic [CAP_W-1:0]  space;
	logic [TOT_W-1:0]  total_written;
	logic [TOT_W-1:0]  total_read;
	logic              input_done;
	logic              at_eof;

	modport source (output valid, output data_out, output ok, output fill,
		output space, output total_written, output total_read,
		output input_done, output at_eof, input ready);
	modport sink (input valid, input data_out, input ok, input fill,
		input space, input total_written, input total_read,
		input input_done, input at_eof, output ready);
endinterface
`default_nettype wire

// ===== src/flow_controlled_byte_fifo_top.sv =====
// top level of the flow controlled byte fifo: channels, register port, assertions
`default_nettype none
// Byte fifo over a ring memory of DEPTH bytes, one result transaction for every
// input transaction. Write byte, drop, end input and spare codes need no
// memory read; read and peek pass ST_MEMRD, as the ring has one registered read port.
// A result sits in an output register, and the next input transaction is taken
// in the same cycle the waiting result is taken. The capacity register (byte
// address 0, reset 4096) limits the fill and is clipped to DEPTH; write it
// only while the block is idle. There is no clearing pass after reset.
module flow_controlled_byte_fifo_top #(
	parameter int DEPTH = fcbf_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	fcbf_in_if.sink                            in_ch,
	fcbf_out_if.source                         out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fcbf_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [fcbf_pkg::PDATA_W-1:0]  pwdata,
	output logic [fcbf_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready
);
	import fcbf_pkg::*;

	logic [CAP_W-1:0] cap_q;
	in_item_t         item;
	res_t             res;
	cmd_t             cmd;
	sts_t             sts;
	logic             out_valid;
	logic             in_ready;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	// input transaction fields
	assign item.opcode     = in_ch.opcode;
	assign item.data_in    = in_ch.data_in;
	assign item.offset     = in_ch.offset;
	assign item.drop_count = in_ch.drop_count;

	fcbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fcbf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.capacity (cap_q),
		.item     (item),
		.res      (res)
	);

	// result transaction fields
	assign in_ch.ready          = in_ready;
	assign out_ch.valid         = out_valid;
	assign out_ch.data_out      = res.data_out;
	assign out_ch.ok            = res.ok;
	assign out_ch.fill          = res.fill;
	assign out_ch.space         = res.space;
	assign out_ch.total_written = res.total_written;
	assign out_ch.total_read    = res.total_read;
	assign out_ch.input_done    = res.input_done;
	assign out_ch.at_eof        = res.at_eof;

`ifndef ASSERT_OFF
	// a transaction that needs no memory read finishes in the next cycle
	a_fast_op: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ready && in_ch.opcode != OP_READ && in_ch.opcode != OP_PEEK)
		|=> out_valid)
		else $error("single cycle transaction gave no result");

	// fill never goes past the ring depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(res.fill) <= DEPTH))
		else $error("fill above ring depth");

	// free space and fill together stay within the ring
	a_space_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res.space != '0) |-> (int'(res.fill) + int'(res.space) <= DEPTH))
		else $error("fill plus space above ring depth");

	// end of stream only once input has ended and the fifo is empty
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res.at_eof) |-> (res.input_done && res.fill == '0))
		else $error("end of stream with bytes held or input open");
`endif
endmodule
`default_nettype wire

// ===== src/fcbf_ctrl.sv =====
// controller state machine: handshakes and sequencing of one transaction
`default_nettype none
module fcbf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire fcbf_pkg::sts_t sts,
	output fcbf_pkg::cmd_t     cmd
);
	import fcbf_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;
	logic   load;

	// result slot is free when empty or being taken this cycle
	assign out_free = !out_valid_q || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					cmd.accept = 1'b1;
					if (sts.needs_mem) begin
						state_n = ST_MEMRD;
					end else begin
						cmd.fin_now = 1'b1;
					end
				end
			end
			ST_MEMRD: begin
				if (out_free) begin
					cmd.fin_mem = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign load = cmd.fin_now || cmd.fin_mem;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== src/fcbf_dp.sv =====
// datapath: ring memory, pointers, totals and the result register
`default_nettype none
module fcbf_dp #(
	parameter int DEPTH = fcbf_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fcbf_pkg::cmd_t              cmd,
	output fcbf_pkg::sts_t                   sts,
	input  wire logic [fcbf_pkg::CAP_W-1:0]  capacity,
	input  wire fcbf_pkg::in_item_t          item,
	output fcbf_pkg::res_t                   res
);
	import fcbf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 2;
	localparam logic [SW-1:0] DEPTH_SW = SW'(DEPTH);

	// ring memory
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// fifo state
	logic [AW-1:0]    head_q;
	logic [CAP_W-1:0] fill_q;
	logic [TOT_W-1:0] wr_tot_q;
	logic [TOT_W-1:0] rd_tot_q;
	logic             ended_q;

	// pending read or peek
	op_t  op_q;
	logic pend_ok_q;

	res_t res_q;

	logic [SW-1:0]    cap_ext;
	logic [SW-1:0]    cap_eff;
	logic [SW-1:0]    fill_ext;
	logic             can_wr;
	logic             peek_ok;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [CNT_W-1:0] drop_n;
	op_t              in_op;

	logic [AW-1:0]     head_n;
	logic [CAP_W-1:0]  fill_n;
	logic [TOT_W-1:0]  wr_tot_n;
	logic [TOT_W-1:0]  rd_tot_n;
	logic              ended_n;
	logic [DATA_W-1:0] dout_n;
	logic              ok_n;
	logic              mem_we;
	logic [SW-1:0]     space_full;
	logic              load;

	// head plus a position, folded once into the ring
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [SW-1:0] pos);
		logic [SW-1:0] s;
		s = SW'(base) + pos;
		if (s >= DEPTH_SW) begin
			s = s - DEPTH_SW;
		end
		return s[AW-1:0];
	endfunction

	assign in_op = op_t'(item.opcode);

	// effective capacity is the register clipped to the ring depth
	assign cap_ext  = SW'(capacity);
	assign cap_eff  = (cap_ext > DEPTH_SW) ? DEPTH_SW : cap_ext;
	assign fill_ext = SW'(fill_q);
	assign can_wr   = fill_ext < cap_eff;
	assign peek_ok  = SW'(item.offset) < fill_ext;
	assign drop_n   = (item.drop_count > fill_q) ? fill_q : item.drop_count;

	assign wr_addr = wrap_add(head_q, fill_ext);
	assign rd_addr = (in_op == OP_PEEK) ? wrap_add(head_q, SW'(item.offset)) : head_q;

	assign sts.needs_mem = (in_op == OP_READ) || (in_op == OP_PEEK);

	// next fifo state and result of the finishing transaction
	always_comb begin
		head_n   = head_q;
		fill_n   = fill_q;
		wr_tot_n = wr_tot_q;
		rd_tot_n = rd_tot_q;
		ended_n  = ended_q;
		dout_n   = '0;
		ok_n     = 1'b0;
		mem_we   = 1'b0;
		if (cmd.fin_mem) begin
			if (pend_ok_q) begin
				dout_n = rdata_q;
				ok_n   = 1'b1;
				if (op_q == OP_READ) begin
					head_n   = wrap_add(head_q, SW'(1));
					fill_n   = fill_q - CAP_W'(1);
					rd_tot_n = rd_tot_q + TOT_W'(1);
				end
			end
		end else begin
			unique case (in_op)
				OP_WRITE: begin
					if (can_wr) begin
						mem_we   = cmd.fin_now;
						fill_n   = fill_q + CAP_W'(1);
						wr_tot_n = wr_tot_q + TOT_W'(1);
						ok_n     = 1'b1;
					end
				end
				OP_DROP: begin
					head_n   = wrap_add(head_q, SW'(drop_n));
					fill_n   = fill_q - drop_n;
					rd_tot_n = rd_tot_q + TOT_W'(drop_n);
				end
				OP_END: begin
					ended_n = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign space_full = (cap_eff > SW'(fill_n)) ? (cap_eff - SW'(fill_n)) : '0;
	assign load = cmd.fin_now || cmd.fin_mem;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= item.data_in;
		end
		if (cmd.accept) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// fifo state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			fill_q    <= '0;
			wr_tot_q  <= '0;
			rd_tot_q  <= '0;
			ended_q   <= 1'b0;
			op_q      <= OP_WRITE;
			pend_ok_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				op_q      <= in_op;
				pend_ok_q <= (in_op == OP_PEEK) ? peek_ok : (fill_q != '0);
			end
			if (load) begin
				head_q   <= head_n;
				fill_q   <= fill_n;
				wr_tot_q <= wr_tot_n;
				rd_tot_q <= rd_tot_n;
				ended_q  <= ended_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.data_out      <= dout_n;
			res_q.ok            <= ok_n;
			res_q.fill          <= fill_n;
			res_q.space         <= space_full[CAP_W-1:0];
			res_q.total_written <= wr_tot_n;
			res_q.total_read    <= rd_tot_n;
			res_q.input_done    <= ended_n;
			res_q.at_eof        <= ended_n && (fill_n == '0);
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ===== tb/fcbf_checker.sv =====
// result checker of the byte fifo: watches both channels and the register port, predicts and compares
`timescale 1ns / 1ps
`default_nettype none
module fcbf_checker
	import fcbf_pkg::*;
#(
	parameter int FIFO_DEPTH = DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	fcbf_in_if                      in_ch,
	fcbf_out_if                     out_ch,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic               pready,
	output int unsigned             mismatches,
	output int unsigned             pending,
	output int unsigned             held_bytes,
	output int unsigned             checked
);

	// predicted fifo contents and status
	logic [DATA_W-1:0] ring_mem [FIFO_DEPTH];
	int unsigned       head_idx;
	int unsigned       fill_now;
	logic [TOT_W-1:0]  wr_total;
	logic [TOT_W-1:0]  rd_total;
	logic              ended;
	logic [CAP_W-1:0]  cap_reg;
	res_t              status_due [$];

	// apply one input transaction to the predicted fifo, return the status it reports
	function automatic res_t predict_status(input in_item_t it);
		res_t        r;
		int unsigned cap;
		int unsigned take;
		r = '0;
		cap = (cap_reg > FIFO_DEPTH) ? FIFO_DEPTH : cap_reg;
		case (it.opcode)
			OP_WRITE: begin
				if (fill_now < cap) begin
					ring_mem[(head_idx + fill_now) % FIFO_DEPTH] = it.data_in;
					fill_now++;
					wr_total++;
					r.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (fill_now > 0) begin
					r.data_out = ring_mem[head_idx];
					head_idx = (head_idx + 1) % FIFO_DEPTH;
					fill_now--;
					rd_total++;
					r.ok = 1'b1;
				end
			end
			OP_PEEK: begin
				if (it.offset < fill_now) begin
					r.data_out = ring_mem[(head_idx + it.offset) % FIFO_DEPTH];
					r.ok = 1'b1;
				end
			end
			OP_DROP: begin
				// clamp to what is held
				take = (it.drop_count > fill_now) ? fill_now : it.drop_count;
				head_idx = (head_idx + take) % FIFO_DEPTH;
				fill_now -= take;
				rd_total += TOT_W'(take);
			end
			OP_END: ended = 1'b1;
			default: ;
		endcase
		r.fill = CAP_W'(fill_now);
		r.space = (cap > fill_now) ? CAP_W'(cap - fill_now) : '0;
		r.total_written = wr_total;
		r.total_read = rd_total;
		r.input_done = ended;
		r.at_eof = ended && (fill_now == 0);
		return r;
	endfunction

	task automatic check_field(input string fname, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// register writes, result compare, then prediction of the newly accepted transaction
	always @(posedge clk or negedge arst_n) begin
		in_item_t item;
		res_t     got;
		res_t     want;
		if (!arst_n) begin
			head_idx = 0;
			fill_now = 0;
			wr_total = '0;
			rd_total = '0;
			ended = 1'b0;
			cap_reg = CAP_RESET;
			status_due.delete();
			mismatches = 0;
			pending = 0;
			held_bytes = 0;
			checked = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_CAPACITY) begin
				cap_reg = pwdata[CAP_W-1:0];
			end
			if (out_ch.valid && out_ch.ready) begin
				got.data_out = out_ch.data_out;
				got.ok = out_ch.ok;
				got.fill = out_ch.fill;
				got.space = out_ch.space;
				got.total_written = out_ch.total_written;
				got.total_read = out_ch.total_read;
				got.input_done = out_ch.input_done;
				got.at_eof = out_ch.at_eof;
				if (status_due.size() == 0) begin
					$display("%0t: result with no transaction outstanding: expected none, actual fill %0d",
						$time, got.fill);
					mismatches++;
				end else begin
					want = status_due.pop_front();
					check_field("data_out", want.data_out, got.data_out);
					check_field("ok", want.ok, got.ok);
					check_field("fill", want.fill, got.fill);
					check_field("space", want.space, got.space);
					check_field("total_written", want.total_written, got.total_written);
					check_field("total_read", want.total_read, got.total_read);
					check_field("input_done", want.input_done, got.input_done);
					check_field("at_eof", want.at_eof, got.at_eof);
					checked++;
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				item.opcode = in_ch.opcode;
				item.data_in = in_ch.data_in;
				item.offset = in_ch.offset;
				item.drop_count = in_ch.drop_count;
				status_due.push_back(predict_status(item));
			end
			pending = status_due.size();
			held_bytes = fill_now;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench top of the byte fifo: clock, reset, stimulus, register writes and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import fcbf_pkg::*;

	localparam int FIFO_DEPTH = DEPTH_DEF;
	localparam int CLK_HALF = 5;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int OFF_MAX = 2**OFF_W - 1;
	localparam int CNT_MAX = 2**CNT_W - 1;
	localparam int CAP_MAX = 2**CAP_W - 1;
	localparam int OP_SPARE_FIRST = int'(OP_END) + 1;
	localparam int OP_SPARE_LAST = 2**3 - 1;
	localparam logic [PADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};

	// random phases: capacity, sender idle and receiver stall percentages
	localparam int unsigned PHASE_CAP [4] = '{16, 5000, 3, 40};
	localparam int unsigned PHASE_SRC [4] = '{0, 51, 0, 29};
	localparam int unsigned PHASE_SINK [4] = '{0, 0, 51, 29};
	localparam int PHASE_ITEMS = 150;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned cap_writes = 0;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned held_bytes;
	int unsigned checked;

	fcbf_in_if  in_ch ();
	fcbf_out_if out_ch ();

	flow_controlled_byte_fifo_top #(
		.DEPTH(FIFO_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	fcbf_checker #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches),
		.pending(pending),
		.held_bytes(held_bytes),
		.checked(checked)
	);

	always #(CLK_HALF) clk = ~clk;

	// receiver stalls
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("flow_controlled_byte_fifo_top regression: fail");
			$finish;
		end
	end

	// one input transaction, entered and left at a falling edge
	task automatic send_op(input logic [2:0] opc, input logic [DATA_W-1:0] data,
		input logic [OFF_W-1:0] off, input logic [CNT_W-1:0] cnt);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= opc;
		in_ch.data_in <= data;
		in_ch.offset <= off;
		in_ch.drop_count <= cnt;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// hold off the sender until every result is back
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// setup and access cycles of a capacity write
	task automatic write_capacity(input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_CAPACITY;
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_writes++;
	endtask

	// random operation, offsets mostly near the current fill, drop counts mostly small
	task automatic random_op();
		int unsigned      roll;
		int unsigned      off_hi;
		int unsigned      cnt_hi;
		logic [2:0]       opc;
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] cnt;
		roll = $urandom_range(0, 99);
		if (roll < 45) opc = OP_WRITE;
		else if (roll < 63) opc = OP_READ;
		else if (roll < 77) opc = OP_PEEK;
		else if (roll < 89) opc = OP_DROP;
		else if (roll < 94) opc = OP_END;
		else opc = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		off_hi = (held_bytes + 2 > OFF_MAX) ? OFF_MAX : held_bytes + 2;
		cnt_hi = (held_bytes + 2 > CNT_MAX) ? CNT_MAX : held_bytes + 2;
		if ($urandom_range(0, 9) < 8) off = OFF_W'($urandom_range(0, off_hi));
		else off = OFF_W'($urandom_range(0, OFF_MAX));
		roll = $urandom_range(0, 9);
		if (roll < 7) cnt = CNT_W'($urandom_range(0, 4));
		else if (roll < 9) cnt = CNT_W'($urandom_range(0, cnt_hi));
		else cnt = CNT_W'($urandom_range(0, CNT_MAX));
		send_op(opc, DATA_W'($urandom_range(0, 255)), off, cnt);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_WRITE;
		in_ch.data_in = '0;
		in_ch.offset = '0;
		in_ch.drop_count = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_CAPACITY;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty fifo, field extremes, spare codes, end of input
		send_op(OP_READ, 8'h00, '0, '0);
		send_op(OP_PEEK, 8'h00, '0, '0);
		send_op(OP_DROP, 8'h00, '0, CNT_W'(CNT_MAX));
		send_op(OP_WRITE, 8'h00, '0, '0);
		send_op(OP_WRITE, 8'hff, '0, '0);
		send_op(OP_WRITE, 8'ha5, '0, '0);
		send_op(OP_PEEK, 8'h00, OFF_W'(0), '0);
		send_op(OP_PEEK, 8'h00, OFF_W'(2), '0);
		send_op(OP_PEEK, 8'h00, OFF_W'(3), '0);
		send_op(OP_PEEK, 8'h00, OFF_W'(OFF_MAX), '0);
		send_op(OP_READ, 8'h00, '0, '0);
		for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
			send_op(3'(c), 8'hff, OFF_W'(OFF_MAX), CNT_W'(CNT_MAX));
		end
		send_op(OP_DROP, 8'h00, '0, CNT_W'(1));
		send_op(OP_END, 8'h00, '0, '0);
		send_op(OP_READ, 8'h00, '0, '0);
		send_op(OP_WRITE, 8'h5a, '0, '0);

		// full at a small capacity
		wait_idle();
		write_capacity(2);
		send_op(OP_WRITE, 8'h3c, '0, '0);
		send_op(OP_WRITE, 8'hc3, '0, '0);

		// capacity below the fill, then zero capacity
		wait_idle();
		write_capacity(1);
		send_op(OP_WRITE, 8'h11, '0, '0);
		send_op(OP_READ, 8'h00, '0, '0);
		send_op(OP_READ, 8'h00, '0, '0);
		wait_idle();
		write_capacity(0);
		send_op(OP_WRITE, 8'h22, '0, '0);
		send_op(OP_DROP, 8'h00, '0, CNT_W'(CNT_MAX));

		// capacity above the ring, then a long random stretch
		src_idle_pct = 29;
		sink_stall_pct = 29;
		wait_idle();
		write_capacity(CAP_MAX);
		repeat (3) send_op(OP_WRITE, DATA_W'($urandom_range(0, 255)), '0, '0);
		send_op(OP_PEEK, 8'h00, OFF_W'(FIFO_DEPTH - 1), '0);
		send_op(OP_PEEK, 8'h00, '0, '0);
		send_op(OP_READ, 8'h00, '0, '0);
		send_op(OP_WRITE, DATA_W'($urandom_range(0, 255)), '0, '0);
		send_op(OP_DROP, 8'h00, '0, CNT_W'(CNT_MAX));
		repeat (450) random_op();

		// random phases with different capacities and idling
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			write_capacity(PHASE_CAP[ph]);
			src_idle_pct = PHASE_SRC[ph];
			sink_stall_pct = PHASE_SINK[ph];
			repeat (PHASE_ITEMS) random_op();
		end

		wait_idle();
		repeat (8) @(negedge clk);
		$display("checked %0d results over %0d capacity settings, all opcodes and spare codes",
			checked, cap_writes);
		$display("capacity clipped to the %0d byte ring, sender gaps and receiver stalls up to 51%%",
			FIFO_DEPTH);
		if (mismatches == 0) begin
			$display("flow_controlled_byte_fifo_top regression: pass");
		end else begin
			$display("flow_controlled_byte_fifo_top regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/fcbf_pkg.sv
src/fcbf_in_if.sv
src/fcbf_out_if.sv
src/fcbf_ctrl.sv
src/fcbf_dp.sv
src/flow_controlled_byte_fifo_top.sv
tb/fcbf_checker.sv
tb/tb_top.sv
